/* src/cfe_pkg.sv */
// ----------------------------------------------------------------------------
// cfe_pkg
// Shared types, codes and constants of the cuckoo filter engine.
// ----------------------------------------------------------------------------
package cfe_pkg;

    // Default geometry of the fingerprint table.
    localparam int SLOTS_PER_BUCKET_DEF = 4;
    localparam int MAX_BUCKETS_DEF      = 1024;

    // FNV-1a constants.
    localparam logic [63:0] FNV_BASIS     = 64'hCBF2_9CE4_8422_2325;
    localparam logic [8:0]  FNV_PRIME_LOW = 9'h1B3;
    localparam int          FNV_PRIME_SHIFT = 40;

    // Fingerprint slot width and clamp limits.
    localparam int          FP_W      = 16;
    localparam logic [4:0]  FP_BITS_MIN = 5'd4;
    localparam logic [4:0]  FP_BITS_MAX = 5'd16;

    // LFSR feedback pattern.
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // Register reset values.
    localparam logic [4:0]  FP_BITS_RST    = 5'd8;
    localparam logic [9:0]  KICK_LIMIT_RST = 10'd500;
    localparam logic [3:0]  BIB_RST        = 4'd10;
    localparam logic [15:0] SEED_RST       = 16'd1;

    // Saturation limit of the reported slot count.
    localparam int COUNT_SAT = 8191;

    // Operation codes.
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_UNDEF  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_FP_BITS    = 2'd0;
    localparam logic [1:0] REG_KICK_LIMIT = 2'd1;
    localparam logic [1:0] REG_BUCKET_BITS = 2'd2;
    localparam logic [1:0] REG_SEED       = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic        success;
        logic [12:0] stored_count;
        logic [9:0]  kicks_used;
    } t_result;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALT,
        ST_RD_HOME,
        ST_CHK_HOME,
        ST_CHK_ALT,
        ST_KICK_LOOP,
        ST_KICK_SWAP,
        ST_KICK_ALT,
        ST_KICK_NEXT,
        ST_KICK_CHK,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        ADDR_I1,
        ADDR_I2,
        ADDR_B,
        ADDR_ALT
    } t_addr_sel;

    typedef enum logic [1:0] {
        WR_FILL,
        WR_CLEAR,
        WR_SWAP
    } t_wr_op;

    typedef struct packed {
        logic      accept;
        logic      clr_step;
        logic      alt_init;
        logic      alt_step;
        logic      latch_i2;
        logic      rd_en;
        t_addr_sel rd_sel;
        logic      pick_bucket;
        logic      load_alt_b;
        logic      draw_slot;
        logic      wr_en;
        t_wr_op    wr_op;
        logic      cnt_inc;
        logic      cnt_dec;
        logic      kick_clr;
        logic      kick_inc;
        logic      finish;
        logic      ok;
        logic      kicks_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic alt_last;
        logic has_empty;
        logic has_match;
        logic kick_at_limit;
    } t_dp_stat;

endpackage

/* src/cfe_ctrl.sv */
// ----------------------------------------------------------------------------
// cfe_ctrl
// Controller state machine: sequences hashing, bucket reads, writes and the
// eviction walk of the cuckoo filter datapath.
// ----------------------------------------------------------------------------
module cfe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [1:0]        i_mode,
    input  logic              i_last,
    input  cfe_pkg::t_dp_stat i_stat,
    output cfe_pkg::t_dp_cmd  o_cmd,
    output logic              busy
);

    cfe_pkg::t_state r_state, n_state;
    logic [1:0]      r_mode, n_mode;
    logic            r_ok, n_ok;
    logic            r_kres, n_kres;

    // State and operation registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfe_pkg::ST_CLEAR;
            r_mode  <= cfe_pkg::MODE_INSERT;
            r_ok    <= 1'b0;
            r_kres  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_ok    <= n_ok;
            r_kres  <= n_kres;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_ok    = r_ok;
        n_kres  = r_kres;
        o_cmd   = '0;
        o_cmd.rd_sel = cfe_pkg::ADDR_I1;
        o_cmd.wr_op  = cfe_pkg::WR_FILL;
        busy    = 1'b1;
        case (r_state)
            cfe_pkg::ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = cfe_pkg::ST_IDLE;
                end
            end
            cfe_pkg::ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.accept = 1'b1;
                    if (i_last) begin
                        o_cmd.alt_init = 1'b1;
                        n_mode  = i_mode;
                        n_ok    = 1'b0;
                        n_kres  = 1'b0;
                        n_state = cfe_pkg::ST_ALT;
                    end
                end
            end
            cfe_pkg::ST_ALT: begin
                o_cmd.alt_step = 1'b1;
                if (i_stat.alt_last) begin
                    n_state = cfe_pkg::ST_RD_HOME;
                end
            end
            cfe_pkg::ST_RD_HOME: begin
                o_cmd.latch_i2 = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = cfe_pkg::ADDR_I1;
                n_state = cfe_pkg::ST_CHK_HOME;
            end
            cfe_pkg::ST_CHK_HOME, cfe_pkg::ST_CHK_ALT: begin
                if (r_mode == cfe_pkg::MODE_INSERT) begin
                    if (i_stat.has_empty) begin
                        o_cmd.wr_en   = 1'b1;
                        o_cmd.wr_op   = cfe_pkg::WR_FILL;
                        o_cmd.cnt_inc = 1'b1;
                        n_ok    = 1'b1;
                        n_state = cfe_pkg::ST_DONE;
                    end else if (r_state == cfe_pkg::ST_CHK_HOME) begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = cfe_pkg::ADDR_I2;
                        n_state = cfe_pkg::ST_CHK_ALT;
                    end else begin
                        o_cmd.pick_bucket = 1'b1;
                        o_cmd.kick_clr    = 1'b1;
                        n_state = cfe_pkg::ST_KICK_LOOP;
                    end
                end else if (r_mode == cfe_pkg::MODE_LOOKUP ||
                             r_mode == cfe_pkg::MODE_REMOVE) begin
                    if (i_stat.has_match) begin
                        n_ok = 1'b1;
                        if (r_mode == cfe_pkg::MODE_REMOVE) begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_op   = cfe_pkg::WR_CLEAR;
                            o_cmd.cnt_dec = 1'b1;
                        end
                        n_state = cfe_pkg::ST_DONE;
                    end else if (r_state == cfe_pkg::ST_CHK_HOME) begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = cfe_pkg::ADDR_I2;
                        n_state = cfe_pkg::ST_CHK_ALT;
                    end else begin
                        n_state = cfe_pkg::ST_DONE;
                    end
                end else begin
                    // Undefined operation code: report a failure only.
                    n_state = cfe_pkg::ST_DONE;
                end
            end
            cfe_pkg::ST_KICK_LOOP: begin
                if (i_stat.kick_at_limit) begin
                    n_state = cfe_pkg::ST_DONE;
                end else begin
                    o_cmd.draw_slot = 1'b1;
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.rd_sel    = cfe_pkg::ADDR_B;
                    n_state = cfe_pkg::ST_KICK_SWAP;
                end
            end
            cfe_pkg::ST_KICK_SWAP: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_op    = cfe_pkg::WR_SWAP;
                o_cmd.alt_init = 1'b1;
                o_cmd.kick_inc = 1'b1;
                n_state = cfe_pkg::ST_KICK_ALT;
            end
            cfe_pkg::ST_KICK_ALT: begin
                o_cmd.alt_step = 1'b1;
                if (i_stat.alt_last) begin
                    n_state = cfe_pkg::ST_KICK_NEXT;
                end
            end
            cfe_pkg::ST_KICK_NEXT: begin
                o_cmd.load_alt_b = 1'b1;
                o_cmd.rd_en      = 1'b1;
                o_cmd.rd_sel     = cfe_pkg::ADDR_ALT;
                n_state = cfe_pkg::ST_KICK_CHK;
            end
            cfe_pkg::ST_KICK_CHK: begin
                if (i_stat.has_empty) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_op   = cfe_pkg::WR_FILL;
                    o_cmd.cnt_inc = 1'b1;
                    n_ok    = 1'b1;
                    n_kres  = 1'b1;
                    n_state = cfe_pkg::ST_DONE;
                end else begin
                    n_state = cfe_pkg::ST_KICK_LOOP;
                end
            end
            cfe_pkg::ST_DONE: begin
                o_cmd.finish    = 1'b1;
                o_cmd.ok        = r_ok;
                o_cmd.kicks_out = r_kres;
                n_state = cfe_pkg::ST_IDLE;
            end
            default: begin
                n_state = cfe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* src/cfe_datapath.sv */
// ----------------------------------------------------------------------------
// cfe_datapath
// Datapath: key hash, fingerprint and bucket index, alternate bucket hash
// unit, eviction LFSR, bucket memory, slot counter and result register.
// ----------------------------------------------------------------------------
module cfe_datapath #(
    parameter int SLOTS_PER_BUCKET = cfe_pkg::SLOTS_PER_BUCKET_DEF,
    parameter int MAX_BUCKETS      = cfe_pkg::MAX_BUCKETS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cfe_pkg::t_dp_cmd  i_cmd,
    input  cfe_pkg::t_item    i_item,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    output cfe_pkg::t_dp_stat o_stat,
    output cfe_pkg::t_result  o_result,
    output logic              o_result_strobe
);

    localparam int BW       = $clog2(MAX_BUCKETS);
    localparam int MAXB_LOG = $clog2(MAX_BUCKETS + 1) - 1;
    localparam int SW       = $clog2(SLOTS_PER_BUCKET);
    localparam int ROW_W    = SLOTS_PER_BUCKET * cfe_pkg::FP_W;
    localparam int CW       = $clog2(MAX_BUCKETS * SLOTS_PER_BUCKET + 1);
    localparam int RECIP_SH = 19;
    localparam int RECIP    = ((1 << RECIP_SH) + SLOTS_PER_BUCKET - 1) / SLOTS_PER_BUCKET;

    // Configuration registers.
    logic [4:0]  r_fp_bits;
    logic [9:0]  r_kick_limit;
    logic [3:0]  r_bucket_bits;
    logic [15:0] r_lfsr, n_lfsr;

    // Working registers.
    logic [63:0]           r_hash;
    logic [cfe_pkg::FP_W-1:0] r_fp;
    logic [BW-1:0]         r_i1, r_i2, r_b, r_rd_addr, r_clr;
    logic [31:0]           r_ah;
    logic [1:0]            r_astep;
    logic [SW-1:0]         r_vslot;
    logic [9:0]            r_k;
    logic [CW-1:0]         r_count;
    logic [ROW_W-1:0]      r_rd_data;
    cfe_pkg::t_result      r_result;
    logic                  r_strobe;

    logic [ROW_W-1:0] mem [MAX_BUCKETS];

    // Combinational signals.
    logic [63:0]           hx, hash_next;
    logic [31:0]           h32;
    logic [4:0]            fpw;
    logic [cfe_pkg::FP_W-1:0] fp_new;
    logic [3:0]            eff_bits;
    logic [BW-1:0]         mask, alt_b, rd_addr;
    logic [7:0]            alt_byte;
    logic [34:0]           recip_prod;
    logic [15:0]           draw_q;
    logic [31:0]           draw_rem;
    logic [SW-1:0]         fz_idx, fm_idx;
    logic                  any_zero, any_match;
    logic [ROW_W-1:0]      wr_row;
    logic                  mem_we;
    logic [BW-1:0]         mem_waddr;
    logic [ROW_W-1:0]      mem_wdata;
    logic [31:0]           cnt_ext;
    logic [15:0]           seed_val;

    // Key hash: multiply by the FNV prime as a shift plus a small product.
    always_comb begin
        hx        = r_hash ^ {56'b0, i_item.data_byte};
        hash_next = (hx << cfe_pkg::FNV_PRIME_SHIFT) + hx * {55'b0, cfe_pkg::FNV_PRIME_LOW};
        h32       = hash_next[31:0];
    end

    // Fingerprint width clamp and masked fingerprint.
    always_comb begin
        fpw = r_fp_bits;
        if (fpw < cfe_pkg::FP_BITS_MIN) fpw = cfe_pkg::FP_BITS_MIN;
        if (fpw > cfe_pkg::FP_BITS_MAX) fpw = cfe_pkg::FP_BITS_MAX;
        for (int i = 0; i < cfe_pkg::FP_W; i++) begin
            fp_new[i] = h32[i] & (5'(i) < fpw);
        end
        if (fp_new == '0) fp_new = cfe_pkg::FP_W'(1);
    end

    // Bucket mask limited to the table size.
    always_comb begin
        eff_bits = (32'(r_bucket_bits) > MAXB_LOG) ? 4'(MAXB_LOG) : r_bucket_bits;
        for (int i = 0; i < BW; i++) begin
            mask[i] = (5'(i) < {1'b0, eff_bits});
        end
    end

    // Alternate bucket from the finished fingerprint hash.
    always_comb begin
        case (r_astep)
            2'd0:    alt_byte = r_fp[7:0];
            2'd1:    alt_byte = r_fp[15:8];
            default: alt_byte = 8'h00;
        endcase
        alt_b = (r_b ^ r_ah[BW-1:0]) & mask;
    end

    // Next LFSR value and its remainder by the slot count.
    always_comb begin
        n_lfsr     = {1'b0, r_lfsr[15:1]} ^ (r_lfsr[0] ? cfe_pkg::LFSR_TAPS : 16'h0000);
        recip_prod = 35'(n_lfsr) * 35'(RECIP);
        draw_q     = recip_prod[34:RECIP_SH];
        draw_rem   = 32'(n_lfsr) - 32'(draw_q) * 32'(SLOTS_PER_BUCKET);
        seed_val   = (i_cfg_data == 16'h0000) ? 16'h0001 : i_cfg_data;
    end

    // Slot search in the bucket just read.
    always_comb begin
        any_zero  = 1'b0;
        any_match = 1'b0;
        fz_idx    = '0;
        fm_idx    = '0;
        for (int j = SLOTS_PER_BUCKET - 1; j >= 0; j--) begin
            if (r_rd_data[j*cfe_pkg::FP_W +: cfe_pkg::FP_W] == '0) begin
                any_zero = 1'b1;
                fz_idx   = SW'(j);
            end
            if (r_rd_data[j*cfe_pkg::FP_W +: cfe_pkg::FP_W] == r_fp) begin
                any_match = 1'b1;
                fm_idx    = SW'(j);
            end
        end
    end

    // Modified bucket row.
    always_comb begin
        wr_row = r_rd_data;
        case (i_cmd.wr_op)
            cfe_pkg::WR_FILL:  wr_row[fz_idx*cfe_pkg::FP_W +: cfe_pkg::FP_W] = r_fp;
            cfe_pkg::WR_CLEAR: wr_row[fm_idx*cfe_pkg::FP_W +: cfe_pkg::FP_W] = '0;
            cfe_pkg::WR_SWAP:  wr_row[r_vslot*cfe_pkg::FP_W +: cfe_pkg::FP_W] = r_fp;
            default:           wr_row = r_rd_data;
        endcase
    end

    // Memory port selection.
    always_comb begin
        case (i_cmd.rd_sel)
            cfe_pkg::ADDR_I1: rd_addr = r_i1;
            cfe_pkg::ADDR_I2: rd_addr = r_i2;
            cfe_pkg::ADDR_B:  rd_addr = r_b;
            default:          rd_addr = alt_b;
        endcase
        mem_we    = i_cmd.clr_step | i_cmd.wr_en;
        mem_waddr = i_cmd.clr_step ? r_clr : r_rd_addr;
        mem_wdata = i_cmd.clr_step ? '0 : wr_row;
    end

    // Bucket memory.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Control registers: configuration, LFSR, counters, result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fp_bits     <= cfe_pkg::FP_BITS_RST;
            r_kick_limit  <= cfe_pkg::KICK_LIMIT_RST;
            r_bucket_bits <= cfe_pkg::BIB_RST;
            r_lfsr        <= cfe_pkg::SEED_RST;
            r_hash        <= cfe_pkg::FNV_BASIS;
            r_count       <= '0;
            r_clr         <= '0;
            r_astep       <= '0;
            r_k           <= '0;
            r_strobe      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cfe_pkg::REG_FP_BITS:     r_fp_bits     <= i_cfg_data[4:0];
                    cfe_pkg::REG_KICK_LIMIT:  r_kick_limit  <= i_cfg_data[9:0];
                    cfe_pkg::REG_BUCKET_BITS: r_bucket_bits <= i_cfg_data[3:0];
                    cfe_pkg::REG_SEED:        r_lfsr        <= seed_val;
                    default:                  r_lfsr        <= r_lfsr;
                endcase
            end else if (i_cmd.pick_bucket || i_cmd.draw_slot) begin
                r_lfsr <= n_lfsr;
            end
            if (i_cmd.accept) begin
                r_hash <= i_item.last_byte ? cfe_pkg::FNV_BASIS : hash_next;
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + BW'(1);
            end
            if (i_cmd.alt_init) begin
                r_astep <= '0;
            end else if (i_cmd.alt_step) begin
                r_astep <= r_astep + 2'd1;
            end
            if (i_cmd.kick_clr) begin
                r_k <= '0;
            end else if (i_cmd.kick_inc) begin
                r_k <= r_k + 10'd1;
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec && r_count != '0) begin
                r_count <= r_count - CW'(1);
            end
            r_strobe <= i_cmd.finish;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_item.last_byte) begin
            r_fp <= fp_new;
            r_i1 <= h32[BW-1:0] & mask;
            r_b  <= h32[BW-1:0] & mask;
        end else if (i_cmd.wr_en && i_cmd.wr_op == cfe_pkg::WR_SWAP) begin
            r_fp <= r_rd_data[r_vslot*cfe_pkg::FP_W +: cfe_pkg::FP_W];
        end
        if (i_cmd.pick_bucket) begin
            r_b <= n_lfsr[0] ? r_i2 : r_i1;
        end else if (i_cmd.load_alt_b) begin
            r_b <= alt_b;
        end
        if (i_cmd.latch_i2) begin
            r_i2 <= alt_b;
        end
        if (i_cmd.rd_en) begin
            r_rd_addr <= rd_addr;
        end
        if (i_cmd.alt_init) begin
            r_ah <= cfe_pkg::FNV_BASIS[31:0];
        end else if (i_cmd.alt_step) begin
            r_ah <= (r_ah ^ {24'b0, alt_byte}) * {23'b0, cfe_pkg::FNV_PRIME_LOW};
        end
        if (i_cmd.draw_slot) begin
            r_vslot <= draw_rem[SW-1:0];
        end
        if (i_cmd.finish) begin
            r_result.success      <= i_cmd.ok;
            r_result.stored_count <= (cnt_ext > 32'(cfe_pkg::COUNT_SAT)) ?
                                     13'(cfe_pkg::COUNT_SAT) : cnt_ext[12:0];
            r_result.kicks_used   <= i_cmd.kicks_out ? r_k : 10'd0;
        end
    end

    assign cnt_ext = 32'(r_count);

    // Status to the controller.
    always_comb begin
        o_stat.clr_last      = (32'(r_clr) == 32'(MAX_BUCKETS - 1));
        o_stat.alt_last      = (r_astep == 2'd3);
        o_stat.has_empty     = any_zero;
        o_stat.has_match     = any_match;
        o_stat.kick_at_limit = (r_k == r_kick_limit);
    end

    assign o_result        = r_result;
    assign o_result_strobe = r_strobe;

endmodule

/* src/cuckoo_filter_engine.sv */
// A non-final key byte is folded into the key hash; a final byte runs the alternate bucket
// hash, the home and alternate bucket checks and, on a full insert, the eviction walk.
// Throughput: one key byte per cycle; the final byte holds busy until its result is out,
// set by the four-step alternate bucket hash and the single bucket memory port.
// Reset: synchronous; afterwards the table is cleared one bucket a cycle, every bucket in
// turn, with busy high. Results are strobed once and cannot be stalled.
// ----------------------------------------------------------------------------
// cuckoo_filter_engine
// Cuckoo filter over streamed key bytes: insert, lookup and remove by
// fingerprint, with a random-walk eviction on insert.
// ----------------------------------------------------------------------------
module cuckoo_filter_engine #(
    parameter int SLOTS_PER_BUCKET = cfe_pkg::SLOTS_PER_BUCKET_DEF,
    parameter int MAX_BUCKETS      = cfe_pkg::MAX_BUCKETS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  cfe_pkg::t_item   i_item,
    output logic             busy,
    output cfe_pkg::t_result o_result,
    output logic             o_result_strobe,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data
);

    cfe_pkg::t_dp_cmd  cmd;
    cfe_pkg::t_dp_stat stat;

    // Controller.
    cfe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_item.mode),
        .i_last  (i_item.last_byte),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Datapath with the bucket memory.
    cfe_datapath #(
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
        .MAX_BUCKETS      (MAX_BUCKETS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_item          (i_item),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_stat          (stat),
        .o_result        (o_result),
        .o_result_strobe (o_result_strobe)
    );

`ifndef SYNTH
    // A result transaction always follows a cycle of work.
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(busy))
        else $error("result strobe without preceding work");

    // Only a successful insert reports evictions.
    a_kicks_on_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && !o_result.success) |-> (o_result.kicks_used == 10'd0))
        else $error("kicks reported on a failed operation");

    // One result per operation: strobes never come back to back.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("back to back result strobes");
`endif

endmodule

/* tb/sv/cfe_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cfe_checker
// Watches the key byte and result channels of the cuckoo filter engine,
// keeps its own copy of the filter table, and compares every result.
// ----------------------------------------------------------------------------
module cfe_checker
    import cfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_item       i_item,
    input  t_result     i_result,
    input  logic        i_result_strobe,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int NUM_SLOTS = SLOTS_PER_BUCKET_DEF * MAX_BUCKETS_DEF;
    localparam logic [63:0] PRIME = 64'h100_0000_01B3;

    // Filter state, mirrored from the block's behavior.
    logic [15:0] fp_table [NUM_SLOTS];
    logic [63:0] key_hash;
    logic [15:0] walk_lfsr;
    logic [31:0] entry_count;
    logic [4:0]  fp_bits_reg;
    logic [9:0]  kick_limit_reg;
    logic [3:0]  bucket_bits_reg;

    t_result expected_results[$];
    int      fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();

    // Advances the walk LFSR and returns its new value modulo n.
    function automatic int unsigned lfsr_pick(int unsigned n);
        logic bit_out;
        bit_out   = walk_lfsr[0];
        walk_lfsr = walk_lfsr >> 1;
        if (bit_out) walk_lfsr = walk_lfsr ^ LFSR_TAPS;
        return walk_lfsr % n;
    endfunction

    function automatic logic [31:0] index_mask();
        int b;
        b = bucket_bits_reg;
        while (b > 0 && (1 << b) > MAX_BUCKETS_DEF) b--;
        return (32'd1 << b) - 1;
    endfunction

    function automatic logic [31:0] other_bucket(logic [31:0] idx, logic [31:0] fp);
        logic [63:0] h;
        h = FNV_BASIS;
        for (int k = 0; k < 4; k++) begin
            h = h ^ 64'((fp >> (8 * k)) & 32'hFF);
            h = h * PRIME;
        end
        return (idx ^ h[31:0]) & index_mask();
    endfunction

    function automatic int slot_of(logic [31:0] b, logic [15:0] val);
        int idx;
        for (int j = 0; j < SLOTS_PER_BUCKET_DEF; j++) begin
            idx = b * SLOTS_PER_BUCKET_DEF + j;
            if (idx < NUM_SLOTS && fp_table[idx] == val) return idx;
        end
        return -1;
    endfunction

    // Runs the operation of one finished key and returns its result.
    function automatic t_result run_key_op(logic [1:0] mode, logic [31:0] h32);
        t_result     r;
        int          fpw, pos, idx;
        logic [31:0] fp, i1, i2, b;
        logic [15:0] evicted;
        logic        ok;
        int unsigned kicks;
        ok    = 0;
        kicks = 0;
        fpw   = fp_bits_reg < 4 ? 4 : (fp_bits_reg > 16 ? 16 : fp_bits_reg);
        fp    = h32 & ((32'd1 << fpw) - 1);
        if (fp == 0) fp = 1;
        i1 = h32 & index_mask();
        i2 = other_bucket(i1, fp);
        if (mode == MODE_INSERT) begin
            pos = slot_of(i1, 16'd0);
            if (pos < 0) pos = slot_of(i2, 16'd0);
            if (pos >= 0) begin
                fp_table[pos] = fp[15:0];
                entry_count++;
                ok = 1;
            end else begin
                b = (lfsr_pick(2) == 0) ? i1 : i2;
                for (int k = 0; k < kick_limit_reg; k++) begin
                    idx = b * SLOTS_PER_BUCKET_DEF + lfsr_pick(SLOTS_PER_BUCKET_DEF);
                    if (idx >= NUM_SLOTS) break;
                    evicted       = fp_table[idx];
                    fp_table[idx] = fp[15:0];
                    fp            = {16'd0, evicted};
                    b             = other_bucket(b, fp);
                    pos           = slot_of(b, 16'd0);
                    if (pos >= 0) begin
                        fp_table[pos] = fp[15:0];
                        entry_count++;
                        ok    = 1;
                        kicks = k + 1;
                        break;
                    end
                end
            end
        end else if (mode == MODE_LOOKUP || mode == MODE_REMOVE) begin
            pos = slot_of(i1, fp[15:0]);
            if (pos < 0) pos = slot_of(i2, fp[15:0]);
            if (pos >= 0) begin
                ok = 1;
                if (mode == MODE_REMOVE) begin
                    fp_table[pos] = 16'd0;
                    if (entry_count > 0) entry_count--;
                end
            end
        end
        r.success      = ok;
        r.stored_count = entry_count > COUNT_SAT ? 13'(COUNT_SAT) : entry_count[12:0];
        r.kicks_used   = kicks[9:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("cfe_checker: %0t mismatch on %s: got %0d, expected %0d",
                 $time, what, got, want);
        fail_count++;
    endtask

    // Tracks configuration writes, key transactions and results.
    always @(posedge i_clk) begin
        t_result     want;
        logic [63:0] h;
        if (!i_rst_n) begin
            foreach (fp_table[i]) fp_table[i] = '0;
            key_hash        = FNV_BASIS;
            walk_lfsr       = SEED_RST;
            entry_count     = 0;
            fp_bits_reg     = FP_BITS_RST;
            kick_limit_reg  = KICK_LIMIT_RST;
            bucket_bits_reg = BIB_RST;
            expected_results.delete();
            fail_count      = 0;
        end else begin
            if (i_result_strobe) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_result.success !== want.success)
                        report_mismatch("success", i_result.success, want.success);
                    if (i_result.stored_count !== want.stored_count)
                        report_mismatch("stored_count", i_result.stored_count,
                                        want.stored_count);
                    if (i_result.kicks_used !== want.kicks_used)
                        report_mismatch("kicks_used", i_result.kicks_used,
                                        want.kicks_used);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FP_BITS:     fp_bits_reg = i_cfg_data[4:0];
                    REG_KICK_LIMIT:  kick_limit_reg = i_cfg_data[9:0];
                    REG_BUCKET_BITS: bucket_bits_reg = i_cfg_data[3:0];
                    REG_SEED: begin
                        walk_lfsr = (i_cfg_data == 0) ? 16'd1 : i_cfg_data;
                    end
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                h        = (key_hash ^ {56'd0, i_item.data_byte}) * PRIME;
                key_hash = h;
                if (i_item.last_byte) begin
                    key_hash = FNV_BASIS;
                    expected_results.push_back(run_key_op(i_item.mode, h[31:0]));
                end
            end
        end
    end

endmodule

/* tb/sv/tb_cuckoo_filter_engine.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cuckoo_filter_engine
// Streams keys through the cuckoo filter engine: directed corner keys, then
// random phases over several register settings, each bursty and paced.
// ----------------------------------------------------------------------------
module tb_cuckoo_filter_engine;
    import cfe_pkg::*;

    localparam int IDLE_LIMIT = 40000;

    logic        clk;
    logic        rst_n;
    logic        start;
    t_item       item;
    logic        busy;
    t_result     result;
    logic        result_strobe;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    int          sent_items;

    // Keys sent for insertion earlier, reused so lookups and removes hit.
    logic [7:0] key_pool[$][$];

    cuckoo_filter_engine u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .i_item         (item),
        .busy           (busy),
        .o_result       (result),
        .o_result_strobe(result_strobe),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    cfe_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (item),
        .i_result       (result),
        .i_result_strobe(result_strobe),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || result_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_cuckoo_filter_engine: FAIL");
                $finish;
            end
        end
    end

    // Drives one byte and holds it until accepted.
    task automatic send_byte(input logic [1:0] mode, input logic [7:0] b, input logic last);
        start          <= 1'b1;
        item.mode      <= mode;
        item.data_byte <= b;
        item.last_byte <= last;
        @(posedge clk);
        while (busy) @(posedge clk);
        sent_items++;
    endtask

    task automatic gap_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Sends one key; bytes may be separated by random gaps.
    task automatic send_key(input logic [7:0] key[$], input logic [1:0] mode, input bit gaps);
        foreach (key[i]) begin
            send_byte(mode, key[i], i == key.size() - 1);
            if (gaps && $urandom_range(0, 3) == 0) gap_cycles($urandom_range(1, 4));
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_key(output logic [7:0] key[$]);
        int len;
        key.delete();
        len = $urandom_range(0, 7) == 0 ? $urandom_range(5, 9) : $urandom_range(1, 3);
        repeat (len) key.push_back(8'($urandom));
    endtask

    // Random phase: mostly inserts of new keys, lookups and removes of known keys.
    task automatic random_phase(input int n_keys);
        logic [7:0] key[$];
        logic [1:0] mode;
        int         pick, burst;
        bit         gaps;
        burst = $urandom_range(1, 12);
        gaps  = $urandom_range(0, 1);
        for (int k = 0; k < n_keys; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45 || key_pool.size() == 0) begin
                random_key(key);
                mode = MODE_INSERT;
                key_pool.push_back(key);
            end else begin
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                if (pick < 70) mode = MODE_LOOKUP;
                else if (pick < 95) mode = MODE_REMOVE;
                else mode = 2'($urandom_range(0, 3));
            end
            send_key(key, mode, gaps);
            if (--burst == 0) begin
                gap_cycles($urandom_range(1, 20));
                burst = $urandom_range(1, 12);
                gaps  = $urandom_range(0, 1);
            end
        end
    endtask

    initial begin
        logic [7:0] key[$];
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_FP_BITS;
        cfg_data  = '0;
        sent_items = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: byte extremes, every mode, and the undefined mode.
        key = '{8'h00};
        send_key(key, MODE_INSERT, 0);
        send_key(key, MODE_LOOKUP, 0);
        send_key(key, MODE_REMOVE, 0);
        send_key(key, MODE_REMOVE, 0);
        key = '{8'hFF, 8'h55, 8'hAA};
        send_key(key, MODE_LOOKUP, 0);
        send_key(key, MODE_INSERT, 0);
        send_key(key, MODE_UNDEF, 0);
        send_key(key, MODE_LOOKUP, 0);
        drain();

        // Tiny table, 4-bit fingerprints: fills up and forces walks, some failing.
        write_reg(REG_BUCKET_BITS, 16'd0);
        write_reg(REG_FP_BITS, 16'd0);
        write_reg(REG_KICK_LIMIT, 16'd0);
        write_reg(REG_SEED, 16'd0);
        key_pool.delete();
        random_phase(20);
        drain();
        write_reg(REG_KICK_LIMIT, 16'd3);
        write_reg(REG_BUCKET_BITS, 16'd1);
        random_phase(80);
        drain();

        // Widest fingerprints, oversized bucket field clamped to the table.
        write_reg(REG_FP_BITS, 16'd31);
        write_reg(REG_BUCKET_BITS, 16'd15);
        write_reg(REG_KICK_LIMIT, 16'd1023);
        write_reg(REG_SEED, 16'hFFFF);
        key_pool.delete();
        random_phase(200);
        drain();

        // Small table with many kicks allowed.
        write_reg(REG_FP_BITS, 16'd16);
        write_reg(REG_BUCKET_BITS, 16'd3);
        write_reg(REG_KICK_LIMIT, 16'd40);
        write_reg(REG_SEED, 16'($urandom_range(1, 65535)));
        key_pool.delete();
        random_phase(120);
        drain();

        // Mid settings until the byte budget is spent.
        while (sent_items < 1250) begin
            write_reg(REG_FP_BITS, 16'($urandom_range(4, 16)));
            write_reg(REG_BUCKET_BITS, 16'($urandom_range(2, 10)));
            write_reg(REG_KICK_LIMIT, 16'($urandom_range(1, 30)));
            write_reg(REG_SEED, 16'($urandom));
            random_phase(60);
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("tb_cuckoo_filter_engine: PASS");
        end else begin
            $display("tb_cuckoo_filter_engine: FAIL");
        end
        $finish;
    end

endmodule

/* cuckoo_filter_engine.f */
src/cfe_pkg.sv
src/cfe_ctrl.sv
src/cfe_datapath.sv
src/cuckoo_filter_engine.sv
tb/sv/cfe_checker.sv
tb/sv/tb_cuckoo_filter_engine.sv
